FILE: sv/dtt_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer table package
// Shared constants for the deadline timer table: default sizes, request
// codes, result status codes and the packed operation select of the adder.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int DTT_SLOTS     = 8;
    localparam int DTT_TIME_BITS = 32;

    localparam int IN_TIME_W  = 32;
    localparam int TAG_W      = 8;
    localparam int IN_IDX_W   = 3;
    localparam int OUT_SLOT_W = 3;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_SCHEDULED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FIRED     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ACK       = 2'd3;

    typedef struct packed {
        logic sub;
    } dtt_op_t;

endpackage

FILE: sv/dtt_addsub.sv
// ----------------------------------------------------------------------------
// Deadline timer table adder and comparator
// One shared adder that either sums the time and delay or subtracts a
// stored deadline from the time; the carry out then means time >= deadline.
// ----------------------------------------------------------------------------
module dtt_addsub
    import dtt_pkg::*;
#(
    parameter int TIME_BITS = DTT_TIME_BITS
) (
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    input  dtt_op_t              op,
    output logic [TIME_BITS-1:0] result,
    output logic                 carry
);

    logic [TIME_BITS-1:0] b_eff;
    logic [TIME_BITS:0]   sum;

    assign b_eff = b ^ {TIME_BITS{op.sub}};
    assign sum   = {1'b0, a} + {1'b0, b_eff} + {{TIME_BITS{1'b0}}, op.sub};
    assign result = sum[TIME_BITS-1:0];
    assign carry  = sum[TIME_BITS];

endmodule

FILE: sv/deadline_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Deadline timer table
// A table of timer slots with schedule, run, cancel and clear requests.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the s_ channel: the request kind in s_tuser and
// the time, delay, tag and slot index in s_tdata. A schedule stores the sum
// of time and delay in the lowest free slot and returns one beat with that
// slot, or a full status. A run compares every slot against the time and
// returns one beat per expired slot in ascending order, the last one marked
// with m_tlast, or a single acknowledge beat when nothing expired. Cancel and
// clear take effect at once and return nothing.
// A schedule walks the valid bits one slot a cycle from slot 0 up to the
// first free slot. A run compares every slot in turn through the single
// adder and the registered table read, then scans the fire bits and sends
// one beat for each expired slot.
// The block takes a new request only when the sequencer is idle; a result
// beat held in the output register does not stop that. When the receiver
// stalls, the sequencer waits with its next beat until the register frees.
// Reset empties the table; the stored deadlines and tags are not cleared.
// ----------------------------------------------------------------------------
module deadline_timer_table_unit
    import dtt_pkg::*;
#(
    parameter int SLOTS     = DTT_SLOTS,
    parameter int TIME_BITS = DTT_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: now_time [31:0], delay [63:32], tag [71:64], slot_index [74:72].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type [1:0].
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: slot [2:0], fired_tag [10:3].
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [1:0].
    output logic [STATUS_W-1:0]  m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCHED     = 3'd1;
    localparam logic [2:0] ST_RUN_RD    = 3'd2;
    localparam logic [2:0] ST_RUN_CMP   = 3'd3;
    localparam logic [2:0] ST_EMIT_SCAN = 3'd4;
    localparam logic [2:0] ST_EMIT_OUT  = 3'd5;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_W-1:0]     tag;
    } dtt_entry_t;

    dtt_entry_t slot_mem [SLOTS];
    dtt_entry_t rd_reg;
    logic       mem_we;

    logic [2:0]            state_reg, state_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [PTR_W-1:0]      cnt_reg, cnt_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [SLOTS-1:0]      fire_reg, fire_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TIME_BITS-1:0]  delay_reg, delay_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [OUT_SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic                  out_last_reg, out_last_next;

    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      cancel_idx;
    logic                  cancel_ok;
    logic                  out_free;
    dtt_op_t               alu_op;
    logic [TIME_BITS-1:0]  alu_b;
    logic [TIME_BITS-1:0]  alu_res;
    logic                  alu_carry;

    assign idx        = ptr_reg[IDX_W-1:0];
    assign cancel_idx = IDX_W'(s_tdata[74:72]);
    assign cancel_ok  = ({29'd0, s_tdata[74:72]} < 32'(SLOTS));
    assign out_free   = !out_valid_reg || m_tready;

    assign alu_op.sub = (state_reg == ST_RUN_CMP);
    assign alu_b      = alu_op.sub ? rd_reg.deadline : delay_reg;

    dtt_addsub #(
        .TIME_BITS(TIME_BITS)
    ) u_addsub (
        .a      (now_reg),
        .b      (alu_b),
        .op     (alu_op),
        .result (alu_res),
        .carry  (alu_carry)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_tag_reg, out_slot_reg};

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        fire_next       = fire_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        tag_next        = tag_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next   = TIME_BITS'(s_tdata[31:0]);
                    delay_next = TIME_BITS'(s_tdata[63:32]);
                    tag_next   = s_tdata[71:64];
                    ptr_next   = '0;
                    case (s_tuser)
                        REQ_SCHEDULE: begin
                            state_next = ST_SCHED;
                        end
                        REQ_RUN: begin
                            cnt_next   = '0;
                            fire_next  = '0;
                            state_next = ST_RUN_RD;
                        end
                        REQ_CANCEL: begin
                            if (cancel_ok) begin
                                valid_next[cancel_idx] = 1'b0;
                            end
                        end
                        REQ_CLEAR: begin
                            valid_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCHED: begin
                if (ptr_reg == PTR_W'(SLOTS)) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_FULL;
                        out_slot_next   = '0;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else if (!valid_reg[idx]) begin
                    if (out_free) begin
                        mem_we          = 1'b1;
                        valid_next[idx] = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_SCHEDULED;
                        out_slot_next   = OUT_SLOT_W'(idx);
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_RUN_RD: begin
                state_next = ST_RUN_CMP;
            end
            ST_RUN_CMP: begin
                if (valid_reg[idx] && alu_carry) begin
                    fire_next[idx]  = 1'b1;
                    valid_next[idx] = 1'b0;
                    cnt_next        = cnt_reg + 1'b1;
                end
                if (ptr_reg == PTR_W'(SLOTS - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_EMIT_SCAN;
                end else begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_RUN_RD;
                end
            end
            ST_EMIT_SCAN: begin
                if (cnt_reg == '0) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_ACK;
                        out_slot_next   = '0;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else if (fire_reg[idx]) begin
                    state_next = ST_EMIT_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_FIRED;
                    out_slot_next   = OUT_SLOT_W'(idx);
                    out_tag_next    = rd_reg.tag;
                    out_last_next   = (cnt_reg == PTR_W'(1));
                    fire_next[idx]  = 1'b0;
                    cnt_next        = cnt_reg - 1'b1;
                    if (cnt_reg == PTR_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_EMIT_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[idx] <= '{deadline: alu_res, tag: tag_reg};
        end
        rd_reg <= slot_mem[idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            fire_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            fire_reg      <= fire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        delay_reg      <= delay_next;
        tag_reg        <= tag_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

endmodule

FILE: test/dtt_checker.sv
// ----------------------------------------------------------------------------
// Deadline timer table checker
// Watches both channels of the deadline timer table and keeps its own copy
// of the slot table. Every accepted request beat updates that copy and queues
// the result beats it should cause. Every accepted result beat is compared
// field by field with the oldest queued beat. It passes the mismatch count
// and the number of beats still owed to the testbench top.
// ----------------------------------------------------------------------------
module dtt_checker
    import dtt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // s_tdata: now_time [31:0], delay [63:32], tag [71:64], slot_index [74:72].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type [1:0].
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: slot [2:0], fired_tag [10:3].
    input  logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [1:0].
    input  logic [STATUS_W-1:0]  m_tuser,
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   beats_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] slot;
        logic [TAG_W-1:0]      fired_tag;
        logic                  last;
    } timer_beat_t;

    logic                     tmr_valid    [DTT_SLOTS];
    logic [DTT_TIME_BITS-1:0] tmr_deadline [DTT_SLOTS];
    logic [TAG_W-1:0]         tmr_tag      [DTT_SLOTS];
    timer_beat_t              due_beats[$];

    function automatic timer_beat_t make_beat(logic [STATUS_W-1:0] status, int slot,
                                              logic [TAG_W-1:0] fired_tag, logic last);
        timer_beat_t b;
        b.status    = status;
        b.slot      = OUT_SLOT_W'(slot);
        b.fired_tag = fired_tag;
        b.last      = last;
        return b;
    endfunction

    task automatic predict_request(input logic [REQ_W-1:0] kind,
                                   input logic [S_TDATA_W-1:0] data);
        logic [DTT_TIME_BITS-1:0] now_time;
        logic [DTT_TIME_BITS-1:0] delay;
        logic [TAG_W-1:0]         tag;
        logic [IN_IDX_W-1:0]      idx;
        int                       fired;
        now_time = data[31:0];
        delay    = data[63:32];
        tag      = data[71:64];
        idx      = data[74:72];
        fired    = 0;
        case (kind)
            REQ_SCHEDULE: begin
                for (int i = 0; i < DTT_SLOTS; i++) begin
                    if (!tmr_valid[i]) begin
                        tmr_valid[i]    = 1'b1;
                        tmr_deadline[i] = now_time + delay;
                        tmr_tag[i]      = tag;
                        due_beats.push_back(make_beat(STAT_SCHEDULED, i, '0, 1'b1));
                        return;
                    end
                end
                due_beats.push_back(make_beat(STAT_FULL, 0, '0, 1'b1));
            end
            REQ_RUN: begin
                for (int i = 0; i < DTT_SLOTS; i++) begin
                    if (tmr_valid[i] && now_time >= tmr_deadline[i]) begin
                        due_beats.push_back(make_beat(STAT_FIRED, i, tmr_tag[i], 1'b0));
                        tmr_valid[i] = 1'b0;
                        fired++;
                    end
                end
                if (fired == 0) begin
                    due_beats.push_back(make_beat(STAT_ACK, 0, '0, 1'b1));
                end else begin
                    due_beats[$].last = 1'b1;
                end
            end
            REQ_CANCEL: begin
                if (int'(idx) < DTT_SLOTS) begin
                    tmr_valid[idx] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < DTT_SLOTS; i++) begin
                    tmr_valid[i] = 1'b0;
                end
            end
        endcase
    endtask

    task automatic check_result();
        timer_beat_t want;
        if (due_beats.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d slot %0d tag %0d",
                   m_tuser, m_tdata[2:0], m_tdata[10:3]);
            mismatch_count++;
            return;
        end
        want = due_beats.pop_front();
        if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            mismatch_count++;
        end
        if (m_tdata[2:0] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, m_tdata[2:0]);
            mismatch_count++;
        end
        if (m_tdata[10:3] !== want.fired_tag) begin
            $error("fired_tag: expected %0d, got %0d", want.fired_tag, m_tdata[10:3]);
            mismatch_count++;
        end
        if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            mismatch_count++;
        end
    endtask

    initial begin
        mismatch_count = 0;
        beats_owed     = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_beats.delete();
            for (int i = 0; i < DTT_SLOTS; i++) begin
                tmr_valid[i]    = 1'b0;
                tmr_deadline[i] = '0;
                tmr_tag[i]      = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata);
            end
        end
        beats_owed <= due_beats.size();
    end

endmodule

FILE: test/deadline_timer_table_unit_tb.sv
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives schedule, run, cancel and clear requests into the deadline timer
// table: a directed opening covering wrap, a full table, firing runs, empty
// runs, cancel and clear, then random traffic around a moving time base.
// Both sides idle at random in the first two of three phases, not in the last.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module deadline_timer_table_unit_tb
    import dtt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;
    int                   mismatch_count;
    int                   beats_owed;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    logic [31:0]          base_time;

    always #10 aclk = ~aclk;

    deadline_timer_table_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dtt_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .beats_owed     (beats_owed)
    );

    initial m_tready = 1'b0;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [31:0] now_time,
                                input logic [31:0] delay, input logic [TAG_W-1:0] tag,
                                input logic [IN_IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {5'b0, idx, tag, delay, now_time};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic schedule_at(input logic [31:0] now_time, input logic [31:0] delay,
                               input logic [TAG_W-1:0] tag);
        send_request(REQ_SCHEDULE, now_time, delay, tag, IN_IDX_W'($urandom));
    endtask

    task automatic run_at(input logic [31:0] now_time);
        send_request(REQ_RUN, now_time, $urandom, TAG_W'($urandom), IN_IDX_W'($urandom));
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            schedule_at(($urandom_range(0, 9) == 0) ? $urandom : base_time,
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300),
                        TAG_W'($urandom));
        end else if (pick < 78) begin
            base_time = base_time + $urandom_range(0, 120);
            run_at(($urandom_range(0, 9) == 0) ? $urandom : base_time);
        end else if (pick < 96) begin
            send_request(REQ_CANCEL, $urandom, $urandom, TAG_W'($urandom),
                         IN_IDX_W'($urandom_range(0, DTT_SLOTS - 1)));
        end else begin
            send_request(REQ_CLEAR, $urandom, $urandom, TAG_W'($urandom),
                         IN_IDX_W'($urandom));
        end
    endtask

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_SCHEDULE;
        tx_idle_pct = 24;
        rx_idle_pct = 52;
        base_time   = $urandom;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        schedule_at(32'd0, 32'd0, 8'h00);
        schedule_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        for (int i = 2; i < DTT_SLOTS; i++) begin
            schedule_at(32'd1000, 32'(i * 10), TAG_W'(8'h10 + i));
        end
        schedule_at(32'd5, 32'd5, 8'hAA);
        run_at(32'd0);
        schedule_at(32'd0, 32'd3, 8'h55);
        run_at(32'd1030);
        run_at(32'hFFFF_FFFF);
        run_at(32'hFFFF_FFFF);
        send_request(REQ_CANCEL, 32'd0, 32'd0, 8'h00, IN_IDX_W'(DTT_SLOTS - 1));
        schedule_at(32'd100, 32'd0, 8'h3C);
        schedule_at(32'd100, 32'd1, 8'hC3);
        send_request(REQ_CANCEL, 32'd0, 32'd0, 8'h00, 3'd0);
        run_at(32'd101);
        schedule_at(32'd7, 32'd7, 8'h77);
        schedule_at(32'd8, 32'd8, 8'h88);
        send_request(REQ_CLEAR, 32'd0, 32'd0, 8'h00, 3'd0);
        run_at(32'hFFFF_FFFF);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 52 : 0;
            rx_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 24 : 0;
            repeat (49) random_request();
        end
        s_tvalid = 1'b0;

        while (beats_owed != 0) begin
            @(posedge aclk);
        end
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
